// File: rtl/dvd_pkg.sv
// Shared types, constants and calendar functions for the date difference block.
package dvd_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DNUM_W  = 23;   // day number since 0001-01-01
  localparam int unsigned DIFF_W  = 23;
  localparam int unsigned IN_W    = 48;
  localparam int unsigned OUT_W   = 32;

  localparam logic [YEAR_W-1:0]  MAX_YEAR       = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0]  CUTOVER_YEAR   = YEAR_W'(1916);
  localparam logic [MONTH_W-1:0] CUTOVER_MONTH  = MONTH_W'(4);
  localparam logic [DAY_W-1:0]   CUTOVER_DAY    = DAY_W'(14);
  localparam logic [DNUM_W-1:0]  SKIPPED_DAYS   = DNUM_W'(13);
  localparam logic [MONTH_W-1:0] FEBRUARY       = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] DECEMBER       = MONTH_W'(12);
  // Julian leaps through 1916 minus Gregorian count through 1916: 479 - 464
  localparam logic [11:0]        LEAP_OFFSET    = 12'd15;
  // floor(q / 25) = (q * 5243) >> 17, exact for q below 4096
  localparam logic [12:0]        RECIP_25       = 13'd5243;
  localparam int unsigned        RECIP_SHIFT    = 17;

  typedef enum logic [1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_EARLIER = 2'd1,
    ORD_LATER   = 2'd2
  } ordering_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // floor(y / 100): y / 4 then / 25
  function automatic logic [7:0] div100(input logic [YEAR_W-1:0] y);
    logic [24:0] prod;
    prod = 25'(y[YEAR_W-1:2]) * 25'(RECIP_25);
    return prod[RECIP_SHIFT +: 8];
  endfunction

  function automatic logic leap_year(input logic [YEAR_W-1:0] y);
    logic [7:0]  q100;
    logic [11:0] back;
    logic        by4;
    logic        by100;
    logic        by400;
    q100  = div100(y);
    back  = 12'(q100) * 12'd25;
    by4   = (y[1:0] == 2'b00);
    by100 = by4 && (back == y[YEAR_W-1:2]);
    by400 = by100 && (q100[1:0] == 2'b00);
    if (y <= CUTOVER_YEAR) begin
      return by4;
    end
    return (by4 && !by100) || by400;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                   return DAY_W'(30);
      4'd2:                                      return DAY_W'(28);
      default:                                   return DAY_W'(0);
    endcase
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
    case (m)
      4'd1:    return 9'd0;
      4'd2:    return 9'd31;
      4'd3:    return 9'd59;
      4'd4:    return 9'd90;
      4'd5:    return 9'd120;
      4'd6:    return 9'd151;
      4'd7:    return 9'd181;
      4'd8:    return 9'd212;
      4'd9:    return 9'd243;
      4'd10:   return 9'd273;
      4'd11:   return 9'd304;
      4'd12:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

  // leap years in 1..n under the mixed calendar
  function automatic logic [11:0] leaps_through(input logic [YEAR_W-1:0] n);
    logic [7:0] q100;
    q100 = div100(n);
    if (n <= CUTOVER_YEAR) begin
      return 12'(n[YEAR_W-1:2]);
    end
    return 12'(n[YEAR_W-1:2]) - 12'(q100) + 12'(q100[7:2]) + LEAP_OFFSET;
  endfunction

  function automatic logic date_valid(input date_t dt);
    logic [DAY_W-1:0] len;
    logic             ok;
    len = month_len(dt.month);
    if (dt.month == FEBRUARY && leap_year(dt.year)) begin
      len = DAY_W'(29);
    end
    ok = (dt.month != '0) && (dt.month <= DECEMBER) && (dt.year != '0) &&
         (dt.year <= MAX_YEAR) && (dt.day != '0) && (dt.day <= len);
    if (dt.year == CUTOVER_YEAR && dt.month == CUTOVER_MONTH && dt.day < CUTOVER_DAY) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  // day number of a valid date; garbage for an invalid one
  function automatic logic [DNUM_W-1:0] day_number(input date_t dt);
    logic [YEAR_W-1:0] ym1;
    logic [DNUM_W-1:0] n;
    logic              after_cut;
    ym1 = dt.year - YEAR_W'(1);
    n   = DNUM_W'(ym1) * DNUM_W'(365) + DNUM_W'(leaps_through(ym1)) +
          DNUM_W'(month_start(dt.month)) + DNUM_W'(dt.day) - DNUM_W'(1);
    if (dt.month > FEBRUARY && leap_year(dt.year)) begin
      n = n + DNUM_W'(1);
    end
    after_cut = (dt.year > CUTOVER_YEAR) ||
                (dt.year == CUTOVER_YEAR && dt.month > CUTOVER_MONTH) ||
                (dt.year == CUTOVER_YEAR && dt.month == CUTOVER_MONTH &&
                 dt.day >= CUTOVER_DAY);
    if (after_cut) begin
      n = n - SKIPPED_DAYS;
    end
    return n;
  endfunction

endpackage

// File: rtl/date_validate_and_difference.sv
// Top level: validates two dates and returns their day difference and ordering.
// Structure: two register stages; a pair passes the input register, then the result register, where out_tvalid rises.
// Throughput: one date pair per cycle; while a result stalls, the input register takes
// one more pair and then in_tready drops.
// Reset: rst_n is synchronous, active low, and clears both stage valid flags;
// data registers are not reset.
module date_validate_and_difference (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // day_a[4:0], month_a[8:5], year_a[22:9], day_b[27:23], month_b[31:28],
  // year_b[45:32], zero fill [47:46]
  input  logic [dvd_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // valid_a[0], valid_b[1], day_difference[24:2] (signed), ordering[26:25],
  // zero fill [31:27]
  output logic [dvd_pkg::OUT_W-1:0]   out_tdata
);

  // Stage 1: registered input pair
  logic                s1_valid_r;
  dvd_pkg::date_t      a_r, b_r;
  logic                s1_adv;

  // Stage 2: registered result
  logic                out_valid_r;
  logic                va_r, vb_r;
  logic [dvd_pkg::DIFF_W-1:0] diff_r;
  dvd_pkg::ordering_t  ord_r;

  logic                va_nxt, vb_nxt;
  logic [dvd_pkg::DIFF_W-1:0] diff_nxt;
  dvd_pkg::ordering_t  ord_nxt;
  logic [dvd_pkg::DNUM_W-1:0] dn_a, dn_b;
  logic signed [dvd_pkg::DIFF_W:0] wide_diff;

  // result register frees when empty or being drained
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_r.day   <= in_tdata[4:0];
      a_r.month <= in_tdata[8:5];
      a_r.year  <= in_tdata[22:9];
      b_r.day   <= in_tdata[27:23];
      b_r.month <= in_tdata[31:28];
      b_r.year  <= in_tdata[45:32];
    end
  end

  // Closed-form day numbers; difference only counts when both dates exist.
  always_comb begin
    va_nxt    = dvd_pkg::date_valid(a_r);
    vb_nxt    = dvd_pkg::date_valid(b_r);
    dn_a      = dvd_pkg::day_number(a_r);
    dn_b      = dvd_pkg::day_number(b_r);
    wide_diff = $signed({1'b0, dn_a}) - $signed({1'b0, dn_b});
    if (!(va_nxt && vb_nxt)) begin
      diff_nxt = '0;
    end else if (wide_diff > $signed({2'b00, {(dvd_pkg::DIFF_W-1){1'b1}}})) begin
      diff_nxt = {1'b0, {(dvd_pkg::DIFF_W-1){1'b1}}};       // saturate high
    end else if (wide_diff < $signed({2'b11, {(dvd_pkg::DIFF_W-1){1'b0}}})) begin
      diff_nxt = {1'b1, {(dvd_pkg::DIFF_W-1){1'b0}}};       // saturate low
    end else begin
      diff_nxt = wide_diff[dvd_pkg::DIFF_W-1:0];
    end
  end

  // Field-wise ordering on the raw fields: year, then month, then day.
  always_comb begin
    if (a_r.year != b_r.year) begin
      ord_nxt = (a_r.year < b_r.year) ? dvd_pkg::ORD_EARLIER : dvd_pkg::ORD_LATER;
    end else if (a_r.month != b_r.month) begin
      ord_nxt = (a_r.month < b_r.month) ? dvd_pkg::ORD_EARLIER : dvd_pkg::ORD_LATER;
    end else if (a_r.day != b_r.day) begin
      ord_nxt = (a_r.day < b_r.day) ? dvd_pkg::ORD_EARLIER : dvd_pkg::ORD_LATER;
    end else begin
      ord_nxt = dvd_pkg::ORD_EQUAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      va_r   <= va_nxt;
      vb_r   <= vb_nxt;
      diff_r <= diff_nxt;
      ord_r  <= ord_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, ord_r, diff_r, vb_r, va_r};

endmodule
